// File: hdl/pmp_pkg.sv
`default_nettype none

package pmp_pkg;

  localparam int NODE_W        = 11;
  localparam int SLOT_W        = 10;
  localparam int CNT_W         = 11;
  localparam int CNT_EFF_W     = 17;
  localparam int EPOCH_W       = 8;
  localparam int MAX_NODES_DEF = 1024;

  localparam logic [CNT_W-1:0]   NODE_COUNT_RST = 11'd1024;
  localparam logic [NODE_W-1:0]  NONE_NODE      = 11'h7FF;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST     = '1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Mark entry: a mark is live only while its tag equals the current query epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic               first;
    logic               second;
  } mark_t;

  // A node value names a real node if it is non-negative and below the count
  function automatic logic is_node(input logic [NODE_W-1:0] v,
                                   input logic [CNT_EFF_W-1:0] count);
    return !v[NODE_W-1] && ({7'b0, v[SLOT_W-1:0]} < count);
  endfunction

endpackage

`default_nettype wire

// File: hdl/pmp_mark_ram.sv
`default_nettype none

module pmp_mark_ram #(
  parameter int AW = 10
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output pmp_pkg::mark_t       rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire pmp_pkg::mark_t  wr_data
);
  import pmp_pkg::*;

  localparam int DEPTH = 1 << AW;

  mark_t mem [DEPTH];
  mark_t q_r;
  mark_t fwd_data_r;
  logic  fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

`default_nettype wire

// File: hdl/path_meeting_point_unit.sv
`default_nettype none
// Nearest meeting node of two walks over a successor table.
//
// in_*  : stream of items. in_tuser[0] is kind (0 load, 1 query). in_tdata carries
//         slot, successor, start_a, start_b. A load writes one table entry. A query
//         walks from start_a marking nodes, then from start_b, and returns the first
//         node of the second walk marked by the first, or -1.
// out_* : one result per query in out_tdata[10:0]; loads give none.
// cfg_* : write of node_count (always ready); write only while the block is idle.
// Walk:   a query issues its first read when it is taken, then makes one table and mark
//         read per step of each walk, and registers the result from S_DONE into the
//         output register; the next item is taken once the block is back in S_IDLE.
// Marks carry an epoch tag, so no clearing is needed between queries. After reset,
// and after every 255th query, a clearing pass writes tag zero to mark entries 0 to
// MAX_NODES-1; in_tready stays low during it.
// If the receiver stalls, the result holds in the output register; loads are still
// taken, and the next query finishes its walks and waits for the register to drain.
module path_meeting_point_unit #(
  parameter int MAX_NODES = pmp_pkg::MAX_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] slot, [20:10] successor, [31:21] start_a, [42:32] start_b, [47:43] zero
  input  wire logic [47:0] in_tdata,
  // [0] kind
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [10:0] meeting_node, [15:11] zero
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [pmp_pkg::CNT_W-1:0] cfg_data
);
  import pmp_pkg::*;

  localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_A     = 5'b00100,
    S_B     = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [SLOT_W-1:0] v);
    logic [31:0] ext;
    ext = {22'b0, v};
    return ext[AW-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [AW-1:0]       sweep_idx_r, sweep_idx_nxt;
  logic [NODE_W-1:0]   start_b_r, start_b_nxt;
  logic [SLOT_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   ans_r, ans_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_node_r, out_node_nxt;
  logic [CNT_W-1:0]    node_count_r;

  logic [SLOT_W-1:0]   in_slot;
  logic [NODE_W-1:0]   in_succ, in_start_a, in_start_b;
  logic                in_acc, query_acc, load_acc;
  logic [CNT_EFF_W-1:0] count_eff;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  mark_t               wr_data, mark_q;
  logic                hit_first, hit_second;

  logic [NODE_W-1:0]   nt_mem [DEPTH];
  logic [NODE_W-1:0]   nt_q_r;

  assign in_slot    = in_tdata[9:0];
  assign in_succ    = in_tdata[20:10];
  assign in_start_a = in_tdata[31:21];
  assign in_start_b = in_tdata[42:32];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign query_acc = in_acc && (in_tuser[0] == KIND_QUERY);
  assign load_acc  = in_acc && (in_tuser[0] == KIND_LOAD);
  assign cfg_ready = 1'b1;

  assign count_eff = ({6'b0, node_count_r} > CNT_EFF_W'(MAX_NODES)) ?
                     CNT_EFF_W'(MAX_NODES) : {6'b0, node_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  // Successor table: loads write, walks read at the mark address
  always_ff @(posedge clk) begin
    if (load_acc && ({22'b0, in_slot} < 32'(MAX_NODES))) begin
      nt_mem[addr_of(in_slot)] <= in_succ;
    end
    if (rd_en) begin
      nt_q_r <= nt_mem[rd_addr];
    end
  end

  pmp_mark_ram #(
    .AW (AW)
  ) u_mark (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mark_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign hit_first  = (mark_q.tag == epoch_r) && mark_q.first;
  assign hit_second = (mark_q.tag == epoch_r) && mark_q.second;

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    sweep_idx_nxt = sweep_idx_r;
    start_b_nxt   = start_b_r;
    node_nxt      = node_r;
    ans_nxt       = ans_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_node_nxt  = out_node_r;
    rd_en         = 1'b0;
    rd_addr       = addr_of(node_r);
    wr_en         = 1'b0;
    wr_addr       = addr_of(node_r);
    wr_data       = '0;
    case (state_r)
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx_r;
        if (sweep_idx_r == AW'(MAX_NODES - 1)) begin
          sweep_idx_nxt = '0;
          state_nxt     = S_IDLE;
        end else begin
          sweep_idx_nxt = sweep_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (query_acc) begin
          epoch_nxt   = epoch_r + 1'b1;
          start_b_nxt = in_start_b;
          if (is_node(in_start_a, count_eff)) begin
            rd_en     = 1'b1;
            rd_addr   = addr_of(in_start_a[SLOT_W-1:0]);
            node_nxt  = in_start_a[SLOT_W-1:0];
            state_nxt = S_A;
          end else if (is_node(in_start_b, count_eff)) begin
            rd_en     = 1'b1;
            rd_addr   = addr_of(in_start_b[SLOT_W-1:0]);
            node_nxt  = in_start_b[SLOT_W-1:0];
            state_nxt = S_B;
          end else begin
            ans_nxt   = NONE_NODE;
            state_nxt = S_DONE;
          end
        end
      end
      S_A: begin
        if (!hit_first) begin
          wr_en   = 1'b1;
          wr_data = '{tag: epoch_r, first: 1'b1, second: 1'b0};
        end
        if (!hit_first && is_node(nt_q_r, count_eff)) begin
          rd_en    = 1'b1;
          rd_addr  = addr_of(nt_q_r[SLOT_W-1:0]);
          node_nxt = nt_q_r[SLOT_W-1:0];
        end else if (is_node(start_b_r, count_eff)) begin
          // first walk over: start the second
          rd_en     = 1'b1;
          rd_addr   = addr_of(start_b_r[SLOT_W-1:0]);
          node_nxt  = start_b_r[SLOT_W-1:0];
          state_nxt = S_B;
        end else begin
          ans_nxt   = NONE_NODE;
          state_nxt = S_DONE;
        end
      end
      S_B: begin
        if (hit_first) begin
          ans_nxt   = {1'b0, node_r};
          state_nxt = S_DONE;
        end else if (hit_second) begin
          ans_nxt   = NONE_NODE;
          state_nxt = S_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_data = '{tag: epoch_r, first: 1'b0, second: 1'b1};
          if (is_node(nt_q_r, count_eff)) begin
            rd_en    = 1'b1;
            rd_addr  = addr_of(nt_q_r[SLOT_W-1:0]);
            node_nxt = nt_q_r[SLOT_W-1:0];
          end else begin
            ans_nxt   = NONE_NODE;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = ans_r;
          if (epoch_r == EPOCH_LAST) begin
            epoch_nxt = '0;
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      epoch_r     <= '0;
      sweep_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_b_r  <= start_b_nxt;
    node_r     <= node_nxt;
    ans_r      <= ans_nxt;
    out_node_r <= out_node_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_node_r};

  a_query_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> (state_r != S_IDLE))
    else $error("query accepted but walk did not start");

  a_result_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[10:0] == NONE_NODE) || is_node(out_tdata[10:0], count_eff)))
    else $error("result is neither none nor a node in use");

  a_done_waits : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tvalid && !out_tready) |=> (state_r == S_DONE))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/sv/tb_path_meeting_point_unit.sv
`default_nettype none

module tb_path_meeting_point_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pmp_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 265;
  localparam int CALM_AFTER  = 235;
  localparam int SETTLE      = 2 * MAX_NODES_DEF + 8;

  // Successor table, loaded flags and pending meeting nodes, kept in step with the block
  class meet_board;
    bit [NODE_W-1:0]  succ_of [MAX_NODES_DEF];
    bit               loaded  [MAX_NODES_DEF];
    logic [CNT_W-1:0] node_count;
    logic [NODE_W-1:0] pending_meet [$];
    int errors, loads, queries, checked;

    function new();
      node_count = NODE_COUNT_RST;
    endfunction

    function int live_count();
      return (node_count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_count);
    endfunction

    function bit real_node(logic [NODE_W-1:0] v);
      return !v[NODE_W-1] && (int'(v[SLOT_W-1:0]) < live_count());
    endfunction

    // blank flags a walk that would read a table entry never loaded
    function logic [NODE_W-1:0] meet_of(input logic [NODE_W-1:0] sa, sb, output bit blank);
      bit on_a [MAX_NODES_DEF];
      bit on_b [MAX_NODES_DEF];
      logic [NODE_W-1:0] v;
      logic [NODE_W-1:0] meet;
      bit found;
      blank = 0;
      found = 0;
      meet  = NONE_NODE;
      v = sa;
      while (real_node(v) && !on_a[v[SLOT_W-1:0]]) begin
        on_a[v[SLOT_W-1:0]] = 1;
        if (!loaded[v[SLOT_W-1:0]]) blank = 1;
        v = succ_of[v[SLOT_W-1:0]];
      end
      v = sb;
      while (!found && real_node(v) && !on_b[v[SLOT_W-1:0]]) begin
        if (on_a[v[SLOT_W-1:0]]) begin
          meet  = v;
          found = 1;
        end else begin
          on_b[v[SLOT_W-1:0]] = 1;
          if (!loaded[v[SLOT_W-1:0]]) blank = 1;
          v = succ_of[v[SLOT_W-1:0]];
        end
      end
      return meet;
    endfunction

    function void note_item(logic kind, logic [SLOT_W-1:0] slot, logic [NODE_W-1:0] succ,
                            logic [NODE_W-1:0] sa, logic [NODE_W-1:0] sb);
      bit blank;
      if (kind == KIND_LOAD) begin
        succ_of[slot] = succ;
        loaded[slot]  = 1;
        loads++;
      end else begin
        pending_meet = {pending_meet, meet_of(sa, sb, blank)};
        queries++;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_meet(logic [NODE_W-1:0] got);
      logic [NODE_W-1:0] want;
      if (pending_meet.size() == 0) begin
        report($sformatf("meeting_node %0d arrived with no query pending", $signed(got)));
      end else begin
        want = pending_meet.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("meeting_node got %0d, expected %0d", $signed(got), $signed(want)));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;   // [9:0] slot, [20:10] successor, [31:21] start_a, [42:32] start_b
  logic [0:0]        in_tuser;   // [0] kind
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [10:0] meeting_node
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  meet_board board;
  int  items_sent;
  int  settings_seen;
  int  holds_done;
  int  stall_cycles;
  bit  hold_req;
  bit  calm;
  int  phase_nodes [$];

  path_meeting_point_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_meet(out_tdata[NODE_W-1:0]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off on request, steady ready when calm
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && holds_done == 0) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  function automatic void keep_node(int n);
    phase_nodes = {phase_nodes, n};
  endfunction

  // A value that is no node under the count now in effect
  function automatic logic [NODE_W-1:0] past_end();
    int lc;
    lc = board.live_count();
    if (lc < MAX_NODES_DEF) return 11'($urandom_range(1023, lc));
    return {1'b1, 10'($urandom())};
  endfunction

  function automatic logic [NODE_W-1:0] pick_node_value();
    int r;
    r = $urandom_range(0, 99);
    if (phase_nodes.size() == 0 || r < 10) return past_end();
    if (r < 20) return NONE_NODE;
    if (r < 27) return 11'($urandom());
    return 11'(phase_nodes[$urandom_range(0, phase_nodes.size() - 1)]);
  endfunction

  // Called at a falling edge, returns at the falling edge after the transaction
  task automatic offer(logic kind, logic [SLOT_W-1:0] slot, logic [NODE_W-1:0] succ,
                       logic [NODE_W-1:0] sa, logic [NODE_W-1:0] sb);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, sb, sa, succ, slot};
    do @(posedge clk); while (!in_tready);
    board.note_item(kind, slot, succ, sa, sb);
    items_sent++;
    calm = (items_sent > CALM_AFTER);
    @(negedge clk);
  endtask

  task automatic load_entry(logic [SLOT_W-1:0] slot, logic [NODE_W-1:0] succ);
    offer(KIND_LOAD, slot, succ, 11'($urandom()), 11'($urandom()));
  endtask

  task automatic ask(logic [NODE_W-1:0] sa, logic [NODE_W-1:0] sb);
    offer(KIND_QUERY, 10'($urandom()), 11'($urandom()), sa, sb);
  endtask

  // Pick starts whose walks stay on loaded entries; fall back to two empty walks
  task automatic random_query();
    logic [NODE_W-1:0] a, b, sa, sb;
    bit blank, found;
    int tries;
    sa = NONE_NODE;
    sb = NONE_NODE;
    found = 0;
    for (tries = 0; tries < 16 && !found; tries++) begin
      a = pick_node_value();
      b = pick_node_value();
      void'(board.meet_of(a, b, blank));
      if (!blank) begin
        sa = a;
        sb = b;
        found = 1;
      end
    end
    ask(sa, sb);
  endtask

  // Hold input until every result is back and any walk in flight has ended
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (board.pending_meet.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] cnt);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    board.node_count = cnt;
    settings_seen++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int p);
    logic [CNT_W-1:0] cnt;
    int lc;
    case (p % 6)
      0:       cnt = 11'($urandom_range(1, 6));
      1:       cnt = 11'($urandom_range(7, 40));
      2:       cnt = 11'($urandom_range(41, 700));
      3:       cnt = 11'($urandom_range(1, 16));
      4:       cnt = 11'(MAX_NODES_DEF);
      default: cnt = 11'($urandom_range(1025, 2047));
    endcase
    write_count(cnt);
    phase_nodes.delete();
    lc = board.live_count();
    if (lc <= 40) begin
      for (int i = 0; i < lc; i++) keep_node(i);
    end else begin
      repeat (24) keep_node($urandom_range(0, lc - 1));
    end
    // well-formed part: fill the graph, then query it among further loads
    foreach (phase_nodes[i]) load_entry(10'(phase_nodes[i]), pick_node_value());
    if (p == 1) hold_req = 1;
    repeat ($urandom_range(12, 24)) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 9) < 7 && phase_nodes.size() > 0)
          load_entry(10'(phase_nodes[$urandom_range(0, phase_nodes.size() - 1)]),
                     pick_node_value());
        else
          load_entry(10'($urandom()), pick_node_value());
      end else begin
        random_query();
      end
    end
  endtask

  initial begin
    int p;
    board      = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    hold_req   = 0;
    calm       = 0;
    items_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset count: extreme slot and successor values, empty and negative starts
    load_entry(10'd1023, NONE_NODE);
    load_entry(10'd0, 11'd1023);
    load_entry(10'd1, 11'd0);
    ask(11'd1, 11'd1023);
    ask(NONE_NODE, 11'd1);
    ask(11'd1023, NONE_NODE);
    ask(11'h400, 11'd0);

    // Eight nodes: a cycle, a tail into it, a self loop, an edge past the count
    write_count(11'd8);
    load_entry(10'd2, 11'd3);
    load_entry(10'd3, 11'd4);
    load_entry(10'd4, 11'd2);
    load_entry(10'd5, 11'd3);
    load_entry(10'd6, 11'd9);
    load_entry(10'd7, 11'd7);
    load_entry(10'd8, 11'd0);   // beyond the count, stored anyway
    ask(11'd5, 11'd6);
    ask(11'd2, 11'd5);
    ask(11'd7, 11'd7);
    ask(11'd8, 11'd2);
    ask(11'd1, 11'd0);
    ask(11'd1023, 11'd3);

    // Zero count makes every node an end marker
    write_count(11'd0);
    ask(11'd0, 11'd0);
    write_count(11'd1);
    ask(11'd0, 11'd0);
    // Oversized count is limited to the table size; slot 8 is now in use
    write_count(11'd2047);
    ask(11'd8, 11'd1);

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(p);
      p++;
    end

    quiesce();
    if (board.pending_meet.size() > 0)
      board.report($sformatf("%0d expected results never arrived", board.pending_meet.size()));
    $display("covered %0d loads and %0d queries, %0d results checked", board.loads,
             board.queries, board.checked);
    $display("across %0d node-count settings with %0d long receiver hold-off(s)",
             settings_seen, holds_done);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
